// File: src/olr_pkg.sv
package olr_pkg;

   // Model dimensions
   localparam int NFeatures         = 3;
   localparam int NWeights          = NFeatures + 1;
   localparam int WIdxW             = $clog2(NWeights);
   localparam int StepW             = $clog2(NWeights + 1);
   localparam int SIGMOID_TABLE_DEPTH = 256;
   localparam int SigIdxW           = $clog2(SIGMOID_TABLE_DEPTH);
   // The table spans [-8, 8) in Q.16, that is 2^20 codes wide.
   localparam int SigShift          = 20 - SigIdxW;

   // Shared multiplier and accumulator widths
   localparam int MulAW  = 34;
   localparam int MulBW  = 17;
   localparam int ProdW  = MulAW + MulBW;
   localparam int AccW   = ProdW + $clog2(NWeights);
   localparam int DeltaW = 24;
   localparam int ErrW   = 17;
   localparam int LeW    = 33;

   // Fixed-point shifts
   localparam int SumShift  = 12;
   localparam int BiasShift = 16;
   localparam int UpdShift  = 28;

   // The bias input is 1.0 in Q3.12.
   localparam logic signed [MulBW-1:0] FeatOne = 17'sd4096;
   localparam logic [15:0] LrReset = 16'd655;
   localparam longint Q30One = 64'sd1073741824;

   typedef struct packed {
      logic               opcode;
      logic signed [15:0] feature_0;
      logic signed [15:0] feature_1;
      logic signed [15:0] feature_2;
      logic [15:0]        target;
   } req_type;

   typedef struct packed {
      logic [15:0] prediction;
      logic        saturated;
   } rsp_type;

   // Command into the weight bank: the addressed entry is read, and written when en is set.
   typedef struct packed {
      logic                      en;
      logic [WIdxW-1:0]          addr;
      logic signed [DeltaW-1:0]  delta;
   } wb_cmd_type;

   typedef struct packed {
      logic signed [31:0] rd_data;
      logic               clipped;
   } wb_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_SUM,
      ST_LOOK,
      ST_ERR,
      ST_UPD,
      ST_DONE
   } state_type;

   typedef logic [15:0] sig_table_type [SIGMOID_TABLE_DEPTH];

   // Feature j of an item; features beyond the three carried read as zero.
   function automatic logic signed [15:0] feat_of(req_type r, logic [StepW-1:0] j);
      logic signed [15:0] f;
      case (j)
         StepW'(0): f = r.feature_0;
         StepW'(1): f = r.feature_1;
         StepW'(2): f = r.feature_2;
         default:   f = '0;
      endcase
      return f;
   endfunction

   // Unsigned 64-bit quotient by shift and subtract; only evaluated while the table is built.
   function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], n[i]};
         if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // Sigmoid at the centre of each bin, worked out in Q2.30 at elaboration.
   function automatic sig_table_type build_sig_table();
      sig_table_type tbl;
      longint        x;
      longint        acc;
      logic [63:0]   pos;
      logic [63:0]   a;
      logic [63:0]   t;
      logic [63:0]   term;
      logic [63:0]   e;
      logic [63:0]   num;
      logic [63:0]   den;
      logic [63:0]   val;
      for (int k = 0; k < SIGMOID_TABLE_DEPTH; k++) begin
         pos = (64'(2 * k + 1) << 33) >> SigIdxW;
         x   = longint'(pos) - 8 * Q30One;
         a   = (x >= 0) ? 64'(x) : 64'(-x);
         if (a > 64'(8 * Q30One)) begin
            a = 64'(8 * Q30One);
         end
         // Taylor series for exp(-a/8), then squared three times
         t    = a >> 3;
         term = 64'(Q30One);
         acc  = Q30One;
         for (int j = 1; j <= 20; j++) begin
            term = udiv64((term * t) >> 30, 64'(j));
            if ((j & 1) != 0) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         if (acc > Q30One) begin
            acc = Q30One;
         end
         e = 64'(acc);
         for (int j = 0; j < 3; j++) begin
            e = (e * e) >> 30;
         end
         num = (x >= 0) ? 64'(Q30One) : e;
         den = 64'(Q30One) + e;
         val = udiv64((num << 16) + (den >> 1), den);
         if (val > 64'd65535) begin
            val = 64'd65535;
         end
         tbl[k] = val[15:0];
      end
      return tbl;
   endfunction

endpackage

// File: src/olr_mul.sv
module olr_mul
   import olr_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MulAW-1:0]  mul_a,
   input  logic signed [MulBW-1:0]  mul_b,
   output logic signed [ProdW-1:0]  prod
);

   logic signed [ProdW-1:0] prod_ff;
   logic signed [ProdW-1:0] prod_in;

   // One signed product a cycle, registered before anything uses it.
   assign prod_in = ProdW'(mul_a) * ProdW'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// File: src/olr_wbank.sv
module olr_wbank
   import olr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  wb_cmd_type  cmd,
   output wb_stat_type stat
);

   logic signed [31:0] w_ff [NWeights];
   logic signed [32:0] sum_wide;
   logic signed [31:0] w_in;
   logic               clip;

   // Saturating add of the delta to the addressed weight.
   always_comb begin
      sum_wide = {w_ff[cmd.addr][31], w_ff[cmd.addr]} + 33'(cmd.delta);
      clip     = sum_wide[32] != sum_wide[31];
      if (!clip) begin
         w_in = sum_wide[31:0];
      end else if (sum_wide[32]) begin
         w_in = {1'b1, 31'd0};
      end else begin
         w_in = {1'b0, {31{1'b1}}};
      end
   end

   // Weights start at zero and change only on a write command.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NWeights; i++) begin
            w_ff[i] <= '0;
         end
      end else if (cmd.en) begin
         w_ff[cmd.addr] <= w_in;
      end
   end

   assign stat.rd_data = w_ff[cmd.addr];
   assign stat.clipped = cmd.en && clip;

endmodule

// File: src/online_logistic_regression.sv
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  req_type: opcode, features, target
// rsp      out        rsp_valid / rsp_ready  rsp_type: prediction, saturated
// csr      in         csr_we                 csr_wdata: learning rate, Q0.16
//
// One item at a time. A predict and an update both run on the single shared 34x17
// multiplier, which issues one product a cycle: one per weight for the sum, one for
// lr*err and one per feature weight. The sequencer returns to idle before it accepts
// the next transfer.
// Reset clears the weights to zero and sets the learning rate to 655.
// The result sits in an output register; a stalled result holds the sequencer in its
// last state, with the weights already updated.
module online_logistic_regression
   import olr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam sig_table_type SigTable = build_sig_table();

   state_type               state_ff, state_in;
   logic [StepW-1:0]        step_ff, step_in;
   logic signed [AccW-1:0]  acc_ff, acc_in;
   logic signed [31:0]      sum_ff, sum_in;
   logic [15:0]             pred_ff, pred_in;
   logic                    flag_ff, flag_in;
   logic signed [LeW-1:0]   le_ff, le_in;
   req_type                 req_ff, req_in;
   logic [15:0]             lr_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic signed [MulAW-1:0] mul_a;
   logic signed [MulBW-1:0] mul_b;
   logic signed [ProdW-1:0] prod;
   wb_cmd_type              wb_cmd;
   wb_stat_type             wb_stat;

   logic signed [AccW-1:0]  sum_wide;
   logic                    sum_clip;
   logic signed [32:0]      rel;
   logic [SigIdxW-1:0]      sig_idx;
   logic signed [ErrW-1:0]  err;
   logic                    out_free;

   olr_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   olr_wbank u_wbank (
      .clock (clock),
      .reset (reset),
      .cmd   (wb_cmd),
      .stat  (wb_stat)
   );

   // Floor the accumulated sum to Q.16 and clip it to 32 bits.
   always_comb begin
      sum_wide = acc_ff >>> SumShift;
      sum_clip = !((&sum_wide[AccW-1:31]) || !(|sum_wide[AccW-1:31]));
   end

   // Table bin of the clipped sum, clamped at both ends of [-8, 8).
   always_comb begin
      rel = {sum_ff[31], sum_ff} + 33'sd524288;
      if (rel[32]) begin
         sig_idx = '0;
      end else if (|rel[31:20]) begin
         sig_idx = '1;
      end else begin
         sig_idx = rel[19:SigShift];
      end
   end

   assign err      = {1'b0, req_ff.target} - {1'b0, pred_ff};
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Sequencer: next state, multiplier operands and weight bank commands.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      pred_in      = pred_ff;
      flag_in      = flag_ff;
      le_in        = le_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mul_a        = '0;
      mul_b        = '0;
      wb_cmd.en    = 1'b0;
      wb_cmd.addr  = step_ff[WIdxW-1:0];
      wb_cmd.delta = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               acc_in   = '0;
               flag_in  = 1'b0;
               step_in  = '0;
               state_in = ST_MAC;
            end
         end
         // Issue weight times feature, and add the previous product.
         ST_MAC: begin
            mul_a = {{(MulAW - 32){wb_stat.rd_data[31]}}, wb_stat.rd_data};
            if (step_ff == '0) begin
               mul_b = FeatOne;
            end else begin
               mul_b = MulBW'(feat_of(req_ff, step_ff - StepW'(1)));
               acc_in = acc_ff + AccW'(prod);
            end
            if (step_ff == StepW'(NWeights)) begin
               state_in = ST_SUM;
            end else begin
               step_in = step_ff + StepW'(1);
            end
         end
         ST_SUM: begin
            if (!sum_clip) begin
               sum_in = sum_wide[31:0];
            end else if (sum_wide[AccW-1]) begin
               sum_in = {1'b1, 31'd0};
            end else begin
               sum_in = {1'b0, {31{1'b1}}};
            end
            flag_in  = sum_clip;
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            pred_in  = SigTable[sig_idx];
            state_in = req_ff.opcode ? ST_ERR : ST_DONE;
         end
         // Learning rate times error.
         ST_ERR: begin
            mul_a    = {{(MulAW - 16){1'b0}}, lr_ff};
            mul_b    = MulBW'(err);
            step_in  = '0;
            state_in = ST_UPD;
         end
         // Step 0 updates the bias from lr*err; later steps take lr*err*feature.
         ST_UPD: begin
            wb_cmd.en = 1'b1;
            mul_b     = MulBW'(feat_of(req_ff, step_ff));
            if (step_ff == '0) begin
               le_in        = prod[LeW-1:0];
               mul_a        = MulAW'($signed(prod[LeW-1:0]));
               wb_cmd.delta = DeltaW'(prod >>> BiasShift);
            end else begin
               mul_a        = MulAW'(le_ff);
               wb_cmd.delta = DeltaW'(prod >>> UpdShift);
            end
            flag_in = flag_ff || wb_stat.clipped;
            if (step_ff == StepW'(NFeatures)) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + StepW'(1);
            end
         end
         // Hand the result to the output register once it is free.
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.prediction = pred_ff;
               rsp_data_in.saturated  = flag_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         lr_ff        <= LrReset;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            lr_ff <= csr_wdata;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      sum_ff      <= sum_in;
      pred_ff     <= pred_in;
      flag_ff     <= flag_in;
      le_ff       <= le_in;
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A new result appears only from the final state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the final state");

   // A transfer starts the product sequence from its first step.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_MAC && step_ff == '0))
      else $error("transfer did not start the sequence");

   // A predict-only item never reaches the weight update.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK && !req_ff.opcode) |=> (state_ff == ST_DONE))
      else $error("predict item entered the update");

   // The result register is never overwritten while a result waits.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_data_ff))
      else $error("waiting result overwritten");

endmodule

// File: test/online_logistic_regression_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the learning-rate port. It keeps its own copy of the
// weights and the sigmoid table, and from them works out the result of every
// accepted sample. It then compares each result transfer with the oldest expected one.
module online_logistic_regression_checker
   import olr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   output int          mismatches,
   output int          in_flight
);

   localparam longint UnitQ30   = 64'sd1073741824;
   localparam longint WordMax   = 64'sd2147483647;
   localparam longint WordMin   = -64'sd2147483648;
   // The table covers [-8, 8) in Q.16: 2^20 codes, starting 2^19 below zero.
   localparam longint LutSpan   = 64'sd1048576;
   localparam longint LutOffset = 64'sd524288;

   logic [15:0]        sigmoid_lut [SIGMOID_TABLE_DEPTH];
   logic signed [31:0] weights [4];
   logic [15:0]        learn_rate;
   rsp_type            expected_rsp_q [$];
   rsp_type            oldest;

   // Sigmoid at the centre of bin k. It uses a Q2.30 series for exp(-|x|/8), which is
   // squared three times, and then a rounded division into Q0.16.
   function automatic logic [15:0] sigmoid_entry(input int k);
      longint unsigned centre;
      longint unsigned mag;
      longint unsigned step;
      longint unsigned term;
      longint unsigned e;
      longint unsigned num;
      longint unsigned den;
      longint unsigned val;
      longint          x;
      longint          series;
      centre = (longint'(2 * k + 1) << 33) / SIGMOID_TABLE_DEPTH;
      x      = longint'(centre) - 8 * UnitQ30;
      mag    = (x < 0) ? longint'(-x) : longint'(x);
      if (mag > 8 * UnitQ30) begin
         mag = 8 * UnitQ30;
      end
      step   = mag >> 3;
      term   = UnitQ30;
      series = UnitQ30;
      for (int n = 1; n <= 20; n++) begin
         term = ((term * step) >> 30) / longint'(n);
         if (n % 2 == 1) begin
            series = series - longint'(term);
         end else begin
            series = series + longint'(term);
         end
      end
      if (series < 0) begin
         series = 0;
      end
      if (series > UnitQ30) begin
         series = UnitQ30;
      end
      e = series;
      for (int n = 0; n < 3; n++) begin
         e = (e * e) >> 30;
      end
      num = (x >= 0) ? UnitQ30 : e;
      den = UnitQ30 + e;
      val = ((num << 16) + (den >> 1)) / den;
      if (val > 65535) begin
         val = 65535;
      end
      return val[15:0];
   endfunction

   // Clips to the signed 32-bit range and notes any clip.
   function automatic longint clip_word(input longint v, inout bit clipped);
      if (v > WordMax) begin
         clipped = 1'b1;
         return WordMax;
      end
      if (v < WordMin) begin
         clipped = 1'b1;
         return WordMin;
      end
      return v;
   endfunction

   // Scores one sample against the current weights. An update also takes one
   // gradient step on the weights.
   function automatic rsp_type score_and_train(input req_type r);
      longint  feat [3];
      longint  acc;
      longint  total;
      longint  rel;
      longint  err;
      longint  scaled_err;
      int      bin;
      bit      clipped;
      rsp_type res;
      clipped = 1'b0;
      feat[0] = longint'($signed(r.feature_0));
      feat[1] = longint'($signed(r.feature_1));
      feat[2] = longint'($signed(r.feature_2));
      // The bias weighs a constant 1.0 in Q3.12.
      acc = longint'(weights[0]) * 4096;
      for (int i = 0; i < 3; i++) begin
         acc = acc + longint'(weights[i + 1]) * feat[i];
      end
      total = clip_word(acc >>> 12, clipped);
      // Sums outside the table use its end bins.
      rel = total + LutOffset;
      if (rel < 0) begin
         bin = 0;
      end else if (rel >= LutSpan) begin
         bin = SIGMOID_TABLE_DEPTH - 1;
      end else begin
         bin = int'((rel * SIGMOID_TABLE_DEPTH) / LutSpan);
      end
      res.prediction = sigmoid_lut[bin];
      if (r.opcode) begin
         err        = longint'(r.target) - longint'(res.prediction);
         scaled_err = longint'(learn_rate) * err;
         weights[0] = 32'(clip_word(longint'(weights[0]) + (scaled_err >>> 16), clipped));
         for (int i = 0; i < 3; i++) begin
            weights[i + 1] = 32'(clip_word(longint'(weights[i + 1])
                                           + ((scaled_err * feat[i]) >>> 28), clipped));
         end
      end
      res.saturated = clipped;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
   endtask

   initial begin
      mismatches = 0;
      in_flight  = 0;
      for (int k = 0; k < SIGMOID_TABLE_DEPTH; k++) begin
         sigmoid_lut[k] = sigmoid_entry(k);
      end
   end

   // Everything is sampled at the rising edge. The stimulus side reads the counts
   // only at the falling edge.
   always @(posedge clock) begin
      if (reset) begin
         expected_rsp_q.delete();
         learn_rate = LrReset;
         for (int i = 0; i < 4; i++) begin
            weights[i] = '0;
         end
      end else begin
         if (csr_we) begin
            learn_rate = csr_wdata;
         end
         // A result transfer retires the oldest expected result.
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch($sformatf("result transfer with none expected: pred %0d sat %0d",
                                         rsp_data.prediction, rsp_data.saturated));
            end else begin
               oldest = expected_rsp_q.pop_front();
               if (rsp_data.prediction !== oldest.prediction) begin
                  report_mismatch($sformatf("prediction %0d, expected %0d",
                                            rsp_data.prediction, oldest.prediction));
               end
               if (rsp_data.saturated !== oldest.saturated) begin
                  report_mismatch($sformatf("saturated %0d, expected %0d",
                                            rsp_data.saturated, oldest.saturated));
               end
            end
         end
         // A sample transfer queues its result.
         if (req_valid && req_ready) begin
            expected_rsp_q.push_back(score_and_train(req_data));
         end
      end
      in_flight = expected_rsp_q.size();
   end

endmodule

// File: test/online_logistic_regression_tb.sv
`timescale 1ns / 1ps

// Sends directed and random training samples to the block, with random gaps on
// both channels. The learning rate is changed between phases. The checker beside
// the block does the comparing, and this module gives the verdict.
module online_logistic_regression_tb
   import olr_pkg::*;
();

   localparam int CycleLimit    = 1000000;
   localparam int NumPhases     = 8;
   localparam int SamplesPerPhase = 195;
   localparam int SettleCycles  = 20;

   localparam logic              OpPredict = 1'b0;
   localparam logic              OpUpdate  = 1'b1;
   localparam logic signed [15:0] FeatMax  = 16'sh7fff;
   localparam logic signed [15:0] FeatMin  = 16'sh8000;
   localparam logic [15:0]       ProbMax   = 16'hffff;
   localparam logic [15:0]       ProbHalf  = 16'h8000;
   localparam logic [15:0]       RateMax   = 16'hffff;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we    = 1'b0;
   logic [15:0] csr_wdata = '0;

   int mismatches;
   int in_flight;
   int cycles     = 0;
   int stall_left = 0;
   bit calm       = 1'b0;

   always #4 clock = ~clock;

   online_logistic_regression DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   online_logistic_regression_checker model_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .in_flight  (in_flight)
   );

   // Idle lengths: mostly none or short, now and then long. None in a calm phase.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 45) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(1, 3);
      end else if (roll < 96) begin
         return $urandom_range(4, 15);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type make_sample(input logic op, input logic signed [15:0] f0,
                                           input logic signed [15:0] f1,
                                           input logic signed [15:0] f2,
                                           input logic [15:0] tgt);
      req_type r;
      r.opcode    = op;
      r.feature_0 = f0;
      r.feature_1 = f1;
      r.feature_2 = f2;
      r.target    = tgt;
      return r;
   endfunction

   // Features lean towards the extremes, zero and small values within +-2.0.
   function automatic logic signed [15:0] random_feature();
      case ($urandom_range(0, 9))
         0:       return FeatMax;
         1:       return FeatMin;
         2:       return '0;
         3, 4, 5: return 16'($urandom_range(0, 16383) - 8192);
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic req_type random_sample();
      logic        op;
      logic [15:0] tgt;
      op = ($urandom_range(0, 9) < 7) ? OpUpdate : OpPredict;
      case ($urandom_range(0, 4))
         0:       tgt = '0;
         1:       tgt = ProbMax;
         default: tgt = 16'($urandom());
      endcase
      return make_sample(op, random_feature(), random_feature(), random_feature(), tgt);
   endfunction

   // Presents one sample after a random gap and returns at the edge of its transfer.
   // Valid stays high afterwards, so the next call either keeps it up or drops it for a gap.
   task automatic send_sample(input req_type r);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  = r;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   // Holds off new samples until every result has been transferred.
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (in_flight != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_rate(input logic [15:0] rate);
      drain_results();
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = rate;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // The result side stalls at random, apart from in calm phases.
   always @(negedge clock) begin
      if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
         stall_left = pick_gap();
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Run guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("online_logistic_regression verification failed");
         $finish;
      end
   end

   initial begin
      logic [15:0] rate;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset learning rate: zero sum, extreme features and targets, both operations.
      send_sample(make_sample(OpPredict, '0, '0, '0, '0));
      send_sample(make_sample(OpPredict, FeatMax, FeatMax, FeatMax, ProbMax));
      send_sample(make_sample(OpPredict, FeatMin, FeatMin, FeatMin, ProbMax));
      send_sample(make_sample(OpUpdate, '0, '0, '0, ProbMax));
      send_sample(make_sample(OpUpdate, FeatMax, FeatMax, FeatMax, '0));
      send_sample(make_sample(OpUpdate, FeatMin, FeatMin, FeatMin, ProbMax));
      send_sample(make_sample(OpUpdate, FeatMax, FeatMin, '0, ProbHalf));

      // Full learning rate overshoots, which pushes sums past both ends of the table.
      write_rate(RateMax);
      send_sample(make_sample(OpUpdate, FeatMax, FeatMax, FeatMax, ProbMax));
      send_sample(make_sample(OpPredict, FeatMax, FeatMax, FeatMax, '0));
      send_sample(make_sample(OpPredict, FeatMin, FeatMin, FeatMin, '0));
      send_sample(make_sample(OpPredict, FeatMin, FeatMin, FeatMin, ProbMax));
      send_sample(make_sample(OpUpdate, FeatMin, FeatMin, FeatMin, '0));
      send_sample(make_sample(OpUpdate, FeatMin, FeatMax, FeatMin, ProbMax));
      send_sample(make_sample(OpPredict, '0, '0, '0, ProbMax));

      // A zero rate leaves the weights where they are.
      write_rate('0);
      send_sample(make_sample(OpUpdate, FeatMax, FeatMax, FeatMax, '0));
      send_sample(make_sample(OpPredict, FeatMax, FeatMax, FeatMax, '0));

      // The smallest non-zero rate.
      write_rate(16'd1);
      send_sample(make_sample(OpUpdate, FeatMin, FeatMax, 16'sd4096, ProbMax));
      send_sample(make_sample(OpPredict, FeatMin, FeatMax, 16'sd4096, '0));

      // Random phases, each with its own rate and idling pattern.
      for (int p = 0; p < NumPhases; p++) begin
         case (p)
            0:       rate = RateMax;
            1:       rate = '0;
            2:       rate = 16'($urandom_range(1, 255));
            default: rate = 16'($urandom());
         endcase
         write_rate(rate);
         calm = (p % 3 == 2);
         for (int n = 0; n < SamplesPerPhase; n++) begin
            send_sample(random_sample());
            if ($urandom_range(0, 149) == 0) begin
               drain_results();
            end
         end
      end

      drain_results();
      repeat (SettleCycles) @(negedge clock);
      if (mismatches == 0) begin
         $display("online_logistic_regression verification clean");
      end else begin
         $display("online_logistic_regression verification failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/olr_pkg.sv
src/olr_mul.sv
src/olr_wbank.sv
src/online_logistic_regression.sv
test/online_logistic_regression_checker.sv
test/online_logistic_regression_tb.sv
